// ===== src/closest_display_mode_search_top_assert.svh =====
// Assertion macros shared by the closest display mode search RTL.
`ifndef CLOSEST_DISPLAY_MODE_SEARCH_TOP_ASSERT_SVH
`define CLOSEST_DISPLAY_MODE_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define CDMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdms: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CDMS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdms: next-cycle check failed");
`else
`define CDMS_ASSERT_IMP(label, clk, rst, ante, cons)
`define CDMS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/cdms_pkg.sv =====
// Shared constants, codes, types and helpers of the closest display mode search.
`default_nettype none
package cdms_pkg;

  localparam int MAX_MODES = 32;
  localparam int MAX_RATES = 8;

  localparam int MODE_AW  = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int MODE_CW  = $clog2(MAX_MODES + 1);
  localparam int RATE_AW  = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
  localparam int RATE_CW  = $clog2(MAX_RATES + 1);
  localparam int STORE_AW = (MAX_MODES * MAX_RATES > 1) ? $clog2(MAX_MODES * MAX_RATES) : 1;
  localparam int IDX_W    = 5;
  localparam int CMPW     = (MODE_CW > IDX_W) ? MODE_CW : IDX_W;
  localparam int DIM_W    = 14;
  localparam int RATE_W   = 10;
  localparam int DIST_W   = DIM_W + 1;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_MODE = 2'd1,
    OP_ADD_RATE = 2'd2,
    OP_QUERY    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_MODE = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic add_mode;
    logic rc_rd_idx;
    logic add_rate;
    logic scan_init;
    logic mscan;
    logic rc_rd_sel;
    logic rate_setup;
    logic rscan;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic mscan_done;
    logic rate_empty;
    logic rscan_done;
    logic out_free;
  } sts_t;

  function automatic logic [DIM_W-1:0] absdiff_dim(input logic [DIM_W-1:0] a,
                                                   input logic [DIM_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [RATE_W-1:0] absdiff_rate(input logic [RATE_W-1:0] a,
                                                     input logic [RATE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Flat address of one rate slot: each mode owns MAX_RATES consecutive slots.
  function automatic logic [STORE_AW-1:0] rate_addr(input logic [MODE_AW-1:0] mode,
                                                    input logic [RATE_CW-1:0] slot);
    return STORE_AW'(STORE_AW'(mode) * STORE_AW'(MAX_RATES) + STORE_AW'(slot));
  endfunction

endpackage
`default_nettype wire

// ===== src/cdms_ctrl.sv =====
// Controller state machine that sequences clear, append and query work.
`default_nettype none
module cdms_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output cdms_pkg::cmd_t  cmd,
  input  cdms_pkg::sts_t  sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_RADD  = 8'b0000_0100,
    S_MSCAN = 8'b0000_1000,
    S_RCRD  = 8'b0001_0000,
    S_RSET  = 8'b0010_0000,
    S_RSCAN = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          cdms_pkg::OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_EMIT;
          end
          cdms_pkg::OP_ADD_MODE: begin
            cmd.add_mode = 1'b1;
            state_next   = S_EMIT;
          end
          cdms_pkg::OP_ADD_RATE: begin
            cmd.rc_rd_idx = 1'b1;
            state_next    = S_RADD;
          end
          default: begin
            cmd.scan_init = 1'b1;
            state_next    = sts.count_zero ? S_EMIT : S_MSCAN;
          end
        endcase
      end
      S_RADD: begin
        cmd.add_rate = 1'b1;
        state_next   = S_EMIT;
      end
      S_MSCAN: begin
        cmd.mscan = 1'b1;
        if (sts.mscan_done) state_next = S_RCRD;
      end
      S_RCRD: begin
        cmd.rc_rd_sel = 1'b1;
        state_next    = S_RSET;
      end
      S_RSET: begin
        cmd.rate_setup = 1'b1;
        state_next     = sts.rate_empty ? S_EMIT : S_RSCAN;
      end
      S_RSCAN: begin
        cmd.rscan = 1'b1;
        if (sts.rscan_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/cdms_datapath.sv =====
// Datapath: mode and rate tables, scan pointers, best-match tracking and result register.
`default_nettype none
`include "closest_display_mode_search_top_assert.svh"
module cdms_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  cdms_pkg::cmd_t                  cmd,
  output cdms_pkg::sts_t                  sts,
  input  logic [1:0]                      op,
  input  logic [cdms_pkg::IDX_W-1:0]      mode_index,
  input  logic [cdms_pkg::DIM_W-1:0]      width,
  input  logic [cdms_pkg::DIM_W-1:0]      height,
  input  logic [cdms_pkg::RATE_W-1:0]     refresh,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [cdms_pkg::DIM_W-1:0]      width_out,
  output logic [cdms_pkg::DIM_W-1:0]      height_out,
  output logic [cdms_pkg::RATE_W-1:0]     refresh_out,
  output logic                            exact_found,
  output logic [cdms_pkg::IDX_W-1:0]      exact_index
);

  // Latched item.
  cdms_pkg::op_e                     op_q;
  logic [cdms_pkg::IDX_W-1:0]        idx_q;
  logic [cdms_pkg::DIM_W-1:0]        w_q;
  logic [cdms_pkg::DIM_W-1:0]        h_q;
  logic [cdms_pkg::RATE_W-1:0]       rf_q;
  cdms_pkg::status_e                 st_q;

  // Tables.
  logic [cdms_pkg::DIM_W-1:0]        mode_w   [cdms_pkg::MAX_MODES];
  logic [cdms_pkg::DIM_W-1:0]        mode_h   [cdms_pkg::MAX_MODES];
  logic [cdms_pkg::RATE_CW-1:0]      rate_cnt [cdms_pkg::MAX_MODES];
  logic [cdms_pkg::RATE_W-1:0]       rate_mem [cdms_pkg::MAX_MODES * cdms_pkg::MAX_RATES];
  logic [cdms_pkg::MODE_CW-1:0]      mode_count;

  // Registered read data.
  logic [cdms_pkg::DIM_W-1:0]        rd_w;
  logic [cdms_pkg::DIM_W-1:0]        rd_h;
  logic [cdms_pkg::RATE_CW-1:0]      rd_rc;
  logic [cdms_pkg::RATE_W-1:0]       rd_rate;

  // Mode scan.
  logic [cdms_pkg::MODE_CW-1:0]      mptr;
  logic                              mdv;
  logic [cdms_pkg::MODE_AW-1:0]      mtag;
  logic                              ef;
  logic                              have;
  logic [cdms_pkg::MODE_AW-1:0]      sel;
  logic [cdms_pkg::DIST_W-1:0]       bestd;
  logic [cdms_pkg::DIM_W-1:0]        best_w;
  logic [cdms_pkg::DIM_W-1:0]        best_h;

  // Rate scan.
  logic [cdms_pkg::RATE_CW-1:0]      rptr;
  logic [cdms_pkg::RATE_CW-1:0]      rn;
  logic                              rdv;
  logic [cdms_pkg::RATE_AW-1:0]      rtag;
  logic                              have_r;
  logic [cdms_pkg::RATE_W-1:0]       best_rd;
  logic [cdms_pkg::RATE_W-1:0]       ro;

  // Combinational helpers.
  logic                              tbl_full;
  logic [cdms_pkg::MODE_AW-1:0]      wr_m;
  logic [cdms_pkg::MODE_AW-1:0]      idx_a;
  logic                              no_mode;
  logic                              rate_full;
  logic                              rate_we;
  logic                              rc_we;
  logic [cdms_pkg::MODE_AW-1:0]      rc_waddr;
  logic [cdms_pkg::RATE_CW-1:0]      rc_wdata;
  logic                              rc_re;
  logic [cdms_pkg::MODE_AW-1:0]      rc_raddr;
  logic [cdms_pkg::RATE_CW-1:0]      rc_clamped;
  logic                              m_issue;
  logic                              m_hit;
  logic [cdms_pkg::DIST_W-1:0]       m_dist;
  logic                              m_better;
  logic                              r_issue;
  logic                              r_hit;
  logic [cdms_pkg::RATE_W-1:0]       r_dist;
  logic                              r_better;

  assign tbl_full  = (mode_count >= cdms_pkg::MODE_CW'(cdms_pkg::MAX_MODES));
  assign wr_m      = mode_count[cdms_pkg::MODE_AW-1:0];
  assign idx_a     = cdms_pkg::MODE_AW'(idx_q);
  assign no_mode   = (cdms_pkg::CMPW'(idx_q) >= cdms_pkg::CMPW'(mode_count));
  assign rate_full = (rd_rc >= cdms_pkg::RATE_CW'(cdms_pkg::MAX_RATES));
  assign rate_we   = cmd.add_rate && !no_mode && !rate_full;

  assign rc_we     = (cmd.add_mode && !tbl_full) || rate_we;
  assign rc_waddr  = cmd.add_mode ? wr_m : idx_a;
  assign rc_wdata  = cmd.add_mode ? '0 : cdms_pkg::RATE_CW'(rd_rc + 1'b1);
  assign rc_re     = cmd.rc_rd_idx || cmd.rc_rd_sel;
  assign rc_raddr  = cmd.rc_rd_idx ? idx_a : sel;
  assign rc_clamped = rate_full ? cdms_pkg::RATE_CW'(cdms_pkg::MAX_RATES) : rd_rc;

  assign m_issue  = cmd.mscan && (mptr < mode_count);
  assign m_hit    = (rd_w == w_q) && (rd_h == h_q);
  assign m_dist   = cdms_pkg::DIST_W'(cdms_pkg::absdiff_dim(rd_w, w_q))
                  + cdms_pkg::DIST_W'(cdms_pkg::absdiff_dim(rd_h, h_q));
  assign m_better = !have || (m_dist < bestd);

  assign r_issue  = cmd.rscan && (rptr < rn);
  assign r_hit    = (rd_rate == rf_q);
  assign r_dist   = cdms_pkg::absdiff_rate(rd_rate, rf_q);
  assign r_better = !have_r || (r_dist < best_rd);

  assign sts.op         = op_q;
  assign sts.count_zero = (mode_count == '0);
  assign sts.mscan_done = mdv && (m_hit ||
                          (cdms_pkg::MODE_CW'(mtag) == mode_count - cdms_pkg::MODE_CW'(1)));
  assign sts.rate_empty = (rd_rc == '0);
  assign sts.rscan_done = rdv && (r_hit ||
                          (cdms_pkg::RATE_CW'(rtag) == rn - cdms_pkg::RATE_CW'(1)));
  assign sts.out_free   = !out_valid || out_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count <= '0;
      mptr       <= '0;
      mdv        <= 1'b0;
      rptr       <= '0;
      rn         <= '0;
      rdv        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        mode_count <= '0;
      end else if (cmd.add_mode && !tbl_full) begin
        mode_count <= mode_count + 1'b1;
      end
      if (cmd.scan_init) begin
        mptr <= '0;
      end else if (m_issue) begin
        mptr <= mptr + 1'b1;
      end
      mdv <= m_issue;
      if (cmd.rate_setup) begin
        rn   <= rc_clamped;
        rptr <= '0;
      end else if (r_issue) begin
        rptr <= rptr + 1'b1;
      end
      rdv <= r_issue;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Mode size tables.
  always_ff @(posedge clk) begin
    if (cmd.add_mode && !tbl_full) begin
      mode_w[wr_m] <= w_q;
      mode_h[wr_m] <= h_q;
    end
    if (m_issue) begin
      rd_w <= mode_w[mptr[cdms_pkg::MODE_AW-1:0]];
      rd_h <= mode_h[mptr[cdms_pkg::MODE_AW-1:0]];
      mtag <= mptr[cdms_pkg::MODE_AW-1:0];
    end
  end

  // Per-mode rate counts.
  always_ff @(posedge clk) begin
    if (rc_we) begin
      rate_cnt[rc_waddr] <= rc_wdata;
    end
    if (rc_re) begin
      rd_rc <= rate_cnt[rc_raddr];
    end
  end

  // Rate slots.
  always_ff @(posedge clk) begin
    if (rate_we) begin
      rate_mem[cdms_pkg::rate_addr(idx_a, rd_rc)] <= rf_q;
    end
    if (r_issue) begin
      rd_rate <= rate_mem[cdms_pkg::rate_addr(sel, rptr)];
      rtag    <= rptr[cdms_pkg::RATE_AW-1:0];
    end
  end

  // Item, status and search payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= cdms_pkg::op_e'(op);
      idx_q <= mode_index;
      w_q   <= width;
      h_q   <= height;
      rf_q  <= refresh;
      st_q  <= cdms_pkg::ST_OK;
    end
    if (cmd.add_mode && tbl_full) begin
      st_q <= cdms_pkg::ST_FULL;
    end
    if (cmd.add_rate) begin
      st_q <= no_mode ? cdms_pkg::ST_NO_MODE :
              (rate_full ? cdms_pkg::ST_FULL : cdms_pkg::ST_OK);
    end
    if (cmd.scan_init) begin
      ef     <= 1'b0;
      have   <= 1'b0;
      have_r <= 1'b0;
      sel    <= '0;
      ro     <= rf_q;
    end
    if (cmd.mscan && mdv) begin
      if (m_hit) begin
        ef  <= 1'b1;
        sel <= mtag;
      end else if (m_better) begin
        have   <= 1'b1;
        sel    <= mtag;
        bestd  <= m_dist;
        best_w <= rd_w;
        best_h <= rd_h;
      end
    end
    if (cmd.rscan && rdv) begin
      if (r_hit) begin
        ro <= rd_rate;
      end else if (r_better) begin
        have_r  <= 1'b1;
        best_rd <= r_dist;
        ro      <= rd_rate;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= st_q;
      if (op_q == cdms_pkg::OP_QUERY) begin
        width_out   <= (have && !ef) ? best_w : w_q;
        height_out  <= (have && !ef) ? best_h : h_q;
        refresh_out <= ro;
        exact_found <= ef;
        exact_index <= ef ? cdms_pkg::IDX_W'(sel) : '0;
      end else begin
        width_out   <= '0;
        height_out  <= '0;
        refresh_out <= '0;
        exact_found <= 1'b0;
        exact_index <= '0;
      end
    end
  end

  `CDMS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, mode_count <= cdms_pkg::MODE_CW'(cdms_pkg::MAX_MODES))
  `CDMS_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, !out_valid || out_ready)
  `CDMS_ASSERT_IMP(a_mtag_range, clk, rst, cmd.mscan && mdv, cdms_pkg::MODE_CW'(mtag) < mode_count)
  `CDMS_ASSERT_IMP(a_rptr_bound, clk, rst, 1'b1, rptr <= rn)
  `CDMS_ASSERT_NXT(a_emit_valid, clk, rst, cmd.emit, out_valid)

endmodule
`default_nettype wire

// ===== src/closest_display_mode_search_top.sv =====
// Top level of the closest display mode search: stream ports, controller and datapath.
`default_nettype none
// This block keeps a table of up to 32 display modes, each a width, a height and up to
// eight refresh rates, and answers one item at a time with exactly one result transfer.
// The item kind on s_tuser selects clear, mode append, rate append or query. A rate
// append first reads the mode's rate count. A query reads one mode entry a cycle
// from the mode size tables, stopping at the first exact size match, then reads the
// chosen mode's rate count and one rate a cycle from the rate store, again stopping at
// an exact hit. A query on an empty table returns the requested size and refresh
// unchanged. The block takes the next input transfer as soon as the current result
// sits in the output register, even if the consumer has not taken it.
// The tables come up undefined after reset; only the mode count is cleared, and every
// mode entry and its rate count are written when the mode is appended.
module closest_display_mode_search_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: mode_index[4:0], width[18:5], height[32:19], refresh[42:33], zero fill
  input  logic [47:0] s_tdata,
  // s_tuser: op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: status[1:0], width_out[15:2], height_out[29:16], refresh_out[39:30],
  //          exact_found[40], exact_index[45:41], zero fill
  output logic [47:0] m_tdata
);

  cdms_pkg::cmd_t                 cmd;
  cdms_pkg::sts_t                 sts;
  logic [1:0]                     status;
  logic [cdms_pkg::DIM_W-1:0]     width_out;
  logic [cdms_pkg::DIM_W-1:0]     height_out;
  logic [cdms_pkg::RATE_W-1:0]    refresh_out;
  logic                           exact_found;
  logic [cdms_pkg::IDX_W-1:0]     exact_index;

  // The controller owns the input handshake and sequences every item.
  cdms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the tables, the scan state and the output register.
  cdms_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (s_tuser),
    .mode_index  (s_tdata[4:0]),
    .width       (s_tdata[18:5]),
    .height      (s_tdata[32:19]),
    .refresh     (s_tdata[42:33]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .status      (status),
    .width_out   (width_out),
    .height_out  (height_out),
    .refresh_out (refresh_out),
    .exact_found (exact_found),
    .exact_index (exact_index)
  );

  // Result fields are packed from the lowest bit up, with the top bits zero.
  assign m_tdata = {2'b00, exact_index, exact_found, refresh_out, height_out,
                    width_out, status};

endmodule
`default_nettype wire
